>>> hw/rtl/gbfa_pkg.sv
`timescale 1ns / 1ps

package gbfa_pkg;

    // byte ranges of the gb2312 and ascii code spaces
    localparam logic [7:0] HANZI_LO  = 8'hB0;
    localparam logic [7:0] HANZI_HI  = 8'hF7;
    localparam logic [7:0] SYM_LO    = 8'hA1;
    localparam logic [7:0] SYM_HI    = 8'hA3;
    localparam logic [7:0] TRAIL_MIN = 8'hA1;
    localparam logic [7:0] ASCII_LO  = 8'h20;
    localparam logic [7:0] ASCII_HI  = 8'h7E;
    localparam logic [7:0] TERM_BYTE = 8'h00;

    // glyph index arithmetic
    localparam int         IDX_W        = 13;
    localparam logic [IDX_W-1:0] ROW_SIZE     = 13'd94;
    localparam logic [IDX_W-1:0] HANZI_OFFSET = 13'd846;

    localparam int         ADDR_W     = 18;
    localparam logic [ADDR_W-1:0] ASCII_BASE = 18'h3CF80;

    // glyph kinds and column advances
    localparam logic       KIND_WIDE   = 1'b0;
    localparam logic       KIND_NARROW = 1'b1;
    localparam logic [7:0] ADV_WIDE    = 8'd16;
    localparam logic [7:0] ADV_NARROW  = 8'd8;

    // decoder state: pending lead byte and running column
    typedef struct packed {
        logic [7:0] lead_byte;
        logic       lead_pending;
        logic [7:0] cursor_column;
    } state_t;

    // one glyph result
    typedef struct packed {
        logic [ADDR_W-1:0] font_address;
        logic              glyph_kind;
        logic [7:0]        glyph_column;
        logic [2:0]        glyph_page;
    } result_t;

endpackage

>>> hw/rtl/gb2312_font_address_generator.sv
`timescale 1ns / 1ps
// each glyph result is registered in the output buffer before it shows on m_tvalid,
// and a new result waits in the skid slot while the output is stalled
// throughput: one text byte per cycle; the decode is one short stage into a
// two-entry output buffer, so s_tready drops only when both entries are full
// reset: synchronous active-low aresetn clears the pending lead, the column and
// both output slots

module gb2312_font_address_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // text_byte[7:0], start_column[15:8], page_row[18:16], zero
    input  logic        s_tuser,  // string_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // font_address[17:0], glyph_column[25:18],
                                  // glyph_page[28:26], zero
    output logic        m_tuser   // glyph_kind
);
    import gbfa_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    state_t  state_dec;
    logic    accept;
    logic    emit;
    result_t result;
    result_t out_data;

    assign accept = s_tvalid && s_tready;

    // byte classification and address arithmetic
    gbfa_decoder u_decoder (
        .state_cur    (state_reg),
        .text_byte    (s_tdata[7:0]),
        .string_start (s_tuser),
        .start_column (s_tdata[15:8]),
        .page_row     (s_tdata[18:16]),
        .state_next   (state_dec),
        .emit         (emit),
        .result       (result)
    );

    // pending lead and column advance on each accepted request
    assign state_next = accept ? state_dec : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    // result register with skid slot
    gbfa_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && emit),
        .push_data (result),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {3'b0, out_data.glyph_page, out_data.glyph_column, out_data.font_address};
    assign m_tuser = out_data.glyph_kind;

    // decoder state holds between requests
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("decoder state moved without a request");

    // a pending lead is always a valid gb2312 lead byte
    a_lead_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.lead_pending |->
        ((state_reg.lead_byte >= HANZI_LO && state_reg.lead_byte <= HANZI_HI) ||
         (state_reg.lead_byte >= SYM_LO && state_reg.lead_byte <= SYM_HI)))
        else $error("pending lead byte out of range");

    // a stalled glyph stays put until taken
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("glyph result changed while stalled");

endmodule

>>> hw/rtl/gbfa_decoder.sv
`timescale 1ns / 1ps

module gbfa_decoder (
    input  gbfa_pkg::state_t  state_cur,
    input  logic [7:0]        text_byte,
    input  logic              string_start,
    input  logic [7:0]        start_column,
    input  logic [2:0]        page_row,
    output gbfa_pkg::state_t  state_next,
    output logic              emit,
    output gbfa_pkg::result_t result
);
    import gbfa_pkg::*;

    logic [7:0]       col_eff;
    logic             pend_eff;
    logic [7:0]       hz_diff;
    logic [7:0]       sy_diff;
    logic [7:0]       tr_diff;
    logic [7:0]       as_diff;
    logic [IDX_W-1:0] hz_idx;
    logic [IDX_W-1:0] sy_idx;
    logic [IDX_W-1:0] wide_idx;
    logic             is_lead;
    logic             is_ascii;
    logic             is_trail;

    // a new string reloads the column and drops any pending lead
    assign col_eff  = string_start ? start_column : state_cur.cursor_column;
    assign pend_eff = string_start ? 1'b0 : state_cur.lead_pending;

    // byte classes
    assign is_lead  = ((text_byte >= HANZI_LO) && (text_byte <= HANZI_HI)) ||
                      ((text_byte >= SYM_LO) && (text_byte <= SYM_HI));
    assign is_ascii = (text_byte >= ASCII_LO) && (text_byte <= ASCII_HI);
    assign is_trail = text_byte >= TRAIL_MIN;

    // glyph index of a two-byte character
    assign hz_diff  = state_cur.lead_byte - HANZI_LO;
    assign sy_diff  = state_cur.lead_byte - SYM_LO;
    assign tr_diff  = text_byte - TRAIL_MIN;
    assign as_diff  = text_byte - ASCII_LO;
    assign hz_idx   = {6'b0, hz_diff[6:0]} * ROW_SIZE + {5'b0, tr_diff} + HANZI_OFFSET;
    assign sy_idx   = {11'b0, sy_diff[1:0]} * ROW_SIZE + {5'b0, tr_diff};
    assign wide_idx = (state_cur.lead_byte >= HANZI_LO) ? hz_idx : sy_idx;

    // classify the byte and build the result
    always_comb begin
        state_next.lead_byte    = 8'h00;
        state_next.lead_pending = 1'b0;
        state_next.cursor_column = col_eff;
        emit                    = 1'b0;
        result.font_address     = {wide_idx, 5'b0};
        result.glyph_kind       = KIND_WIDE;
        result.glyph_column     = col_eff;
        result.glyph_page       = page_row;

        if (text_byte == TERM_BYTE) begin
            emit = 1'b0;
        end else if (pend_eff && is_trail) begin
            emit = 1'b1;
            state_next.cursor_column = col_eff + ADV_WIDE;
        end else if (is_lead) begin
            state_next.lead_byte    = text_byte;
            state_next.lead_pending = 1'b1;
        end else if (is_ascii) begin
            emit                = 1'b1;
            result.font_address = ASCII_BASE + {7'b0, as_diff[6:0], 4'b0};
            result.glyph_kind   = KIND_NARROW;
            state_next.cursor_column = col_eff + ADV_NARROW;
        end
    end

endmodule

>>> hw/rtl/gbfa_out_buf.sv
`timescale 1ns / 1ps

module gbfa_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  gbfa_pkg::result_t push_data,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gbfa_pkg::result_t out_data
);
    import gbfa_pkg::*;

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_data_reg;
    result_t main_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;

    // upstream may push as long as the skid slot is free
    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // main and skid slot update
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_ready) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || out_ready) begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_ready) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    // the skid slot only fills behind a waiting main slot
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot valid while main slot empty");

    // a stalled skid entry moves to main once taken
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg &&
        main_data_reg == $past(skid_data_reg)))
        else $error("skid entry not moved to main slot");

    // a push into a full-but-stalled main lands in skid
    a_push_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && ready && main_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("request lost while output stalled");

endmodule
